// ===== rtl/sstf_pkg.sv =====
`timescale 1ns / 1ps

package sstf_pkg;

  localparam int POS_W           = 20;
  localparam int CNT_FIELD_W     = 5;
  localparam int QUEUE_DEPTH_DEF = 16;

  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } sstf_op_t;

  typedef struct packed {
    sstf_op_t         op;
    logic [POS_W-1:0] sector_pos;
  } sstf_in_t;

  typedef struct packed {
    logic                   dispatch_valid;
    logic [POS_W-1:0]       dispatch_pos;
    logic [CNT_FIELD_W-1:0] pending_count;
    logic                   add_dropped;
  } sstf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_SCAN,
    ST_PICK,
    ST_RESP
  } sstf_state_t;

endpackage

// ===== rtl/sstf_request_scheduler_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_stall   | sstf_in_t  (op, sector_pos)
// out_     | output    | out_valid / out_stall | sstf_out_t (dispatch_valid, dispatch_pos,
//          |           |                       |             pending_count, add_dropped)
//
// One item at a time; a result sits in the output register while the next item is taken.
// Add without reorder, dropped add or empty dispatch: ST_IDLE then ST_RESP. Dispatch: ST_IDLE,
// ST_DISP, ST_RESP. Add after the first dispatch: an ST_SCAN pass and an ST_PICK per chain slot for
// N queued entries, since the single read port of the position memory is scanned once per chain slot.
// Reset is synchronous and active low; no clearing pass, the queue starts empty.
// out_stall holds the result register; the input stays stalled until the result is loaded.

module sstf_request_scheduler_core import sstf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sstf_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output sstf_out_t out_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_W = (IDX_W + 1)'(QUEUE_DEPTH);

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IDX_W-1:0];
  endfunction

  sstf_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic             bank_r, bank_nxt;
  logic             once_r, once_nxt;
  logic [POS_W-1:0] ref_r, ref_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             d_vld_r, d_vld_nxt;
  logic [IDX_W-1:0] d_idx_r, d_idx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [QUEUE_DEPTH-1:0] used_r, used_nxt;
  logic [POS_W-1:0] anchor_r, anchor_nxt;
  logic             best_vld_r, best_vld_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [POS_W-1:0] best_pos_r, best_pos_nxt;
  logic [POS_W-1:0] best_d_r, best_d_nxt;
  sstf_out_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  sstf_out_t        out_data_r, out_data_nxt;

  logic             add_we;
  logic             pick_we;
  logic [IDX_W-1:0] rd_rel;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [POS_W-1:0] wr_data;
  logic [POS_W-1:0] rd_data0, rd_data1, rd_data;
  logic [POS_W-1:0] seek_d;
  logic             we0, we1;

  assign rd_addr = wrap_add(head_r, rd_rel);
  assign wr_addr = add_we ? wrap_add(head_r, cnt_r[IDX_W-1:0]) : slot_r;
  assign wr_data = add_we ? in_data.sector_pos : best_pos_r;
  assign we0     = (add_we && !bank_r) || (pick_we && bank_r);
  assign we1     = (add_we && bank_r) || (pick_we && !bank_r);
  assign rd_data = bank_r ? rd_data1 : rd_data0;
  assign seek_d  = (rd_data > anchor_r) ? (rd_data - anchor_r) : (anchor_r - rd_data);

  sstf_pos_ram #(.DEPTH(QUEUE_DEPTH), .ADDR_W(IDX_W)) u_ram0 (
    .clk     (clk),
    .wr_en   (we0),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data0)
  );

  sstf_pos_ram #(.DEPTH(QUEUE_DEPTH), .ADDR_W(IDX_W)) u_ram1 (
    .clk     (clk),
    .wr_en   (we1),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data1)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    bank_nxt      = bank_r;
    once_nxt      = once_r;
    ref_nxt       = ref_r;
    k_nxt         = k_r;
    d_vld_nxt     = 1'b0;
    d_idx_nxt     = d_idx_r;
    slot_nxt      = slot_r;
    used_nxt      = used_r;
    anchor_nxt    = anchor_r;
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_pos_nxt  = best_pos_r;
    best_d_nxt    = best_d_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    add_we        = 1'b0;
    pick_we       = 1'b0;
    rd_rel        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          if (in_data.op == OP_ADD) begin
            if (cnt_r == DEPTH_C) begin
              res_nxt.pending_count = CNT_FIELD_W'(cnt_r);
              res_nxt.add_dropped   = 1'b1;
              state_nxt             = ST_RESP;
            end else begin
              add_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
              if (once_r) begin
                k_nxt        = '0;
                slot_nxt     = '0;
                used_nxt     = '0;
                anchor_nxt   = ref_r;
                best_vld_nxt = 1'b0;
                state_nxt    = ST_SCAN;
              end else begin
                res_nxt.pending_count = CNT_FIELD_W'(cnt_nxt);
                state_nxt             = ST_RESP;
              end
            end
          end else if (cnt_r == '0) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_DISP;
          end
        end
      end
      ST_DISP: begin
        cnt_nxt                = cnt_r - CNT_W'(1);
        head_nxt               = wrap_add(head_r, IDX_W'(1));
        once_nxt               = 1'b1;
        ref_nxt                = once_r ? rd_data : '0;
        res_nxt.dispatch_valid = 1'b1;
        res_nxt.dispatch_pos   = rd_data;
        res_nxt.pending_count  = CNT_FIELD_W'(cnt_nxt);
        state_nxt              = ST_RESP;
      end
      ST_SCAN: begin
        rd_rel = k_r[IDX_W-1:0];
        if (d_vld_r && !used_r[d_idx_r] && (!best_vld_r || seek_d < best_d_r)) begin
          best_vld_nxt = 1'b1;
          best_idx_nxt = d_idx_r;
          best_pos_nxt = rd_data;
          best_d_nxt   = seek_d;
        end
        if (k_r != cnt_r) begin
          k_nxt     = k_r + CNT_W'(1);
          d_vld_nxt = 1'b1;
          d_idx_nxt = k_r[IDX_W-1:0];
        end else begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        pick_we              = 1'b1;
        used_nxt[best_idx_r] = 1'b1;
        anchor_nxt           = best_pos_r;
        slot_nxt             = slot_r + IDX_W'(1);
        k_nxt                = '0;
        best_vld_nxt         = 1'b0;
        if (CNT_W'(slot_r) + CNT_W'(1) == cnt_r) begin
          bank_nxt              = !bank_r;
          head_nxt              = '0;
          res_nxt.pending_count = CNT_FIELD_W'(cnt_r);
          state_nxt             = ST_RESP;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      bank_r      <= 1'b0;
      once_r      <= 1'b0;
      ref_r       <= '0;
      k_r         <= '0;
      d_vld_r     <= 1'b0;
      slot_r      <= '0;
      used_r      <= '0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      bank_r      <= bank_nxt;
      once_r      <= once_nxt;
      ref_r       <= ref_nxt;
      k_r         <= k_nxt;
      d_vld_r     <= d_vld_nxt;
      slot_r      <= slot_nxt;
      used_r      <= used_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_idx_r    <= d_idx_nxt;
    anchor_r   <= anchor_nxt;
    best_idx_r <= best_idx_nxt;
    best_pos_r <= best_pos_nxt;
    best_d_r   <= best_d_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/sstf_pos_ram.sv =====
`timescale 1ns / 1ps

module sstf_pos_ram import sstf_pkg::*; #(
  parameter int DEPTH  = QUEUE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(QUEUE_DEPTH_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [POS_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [POS_W-1:0]  rd_data
);

  logic [POS_W-1:0] mem [DEPTH];
  logic [POS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sstf_checker.sv =====
`timescale 1ns / 1ps

module sstf_checker import sstf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input sstf_out_t out_data
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sstf_request_scheduler_core sstf_checker u_sstf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import sstf_pkg::*; ();

  localparam int QDEPTH      = QUEUE_DEPTH_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 320;
  localparam int N_RANDOM    = 1500;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} load_phase_t;
  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  sstf_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sstf_out_t out_data;

  sstf_in_t  stim_q[$];
  sstf_out_t awaited[$];
  bit        in_fire;
  bit        out_fire;
  int        errors      = 0;
  int        idle_cycles = 0;
  int        burst_left  = 0;
  int        gap_left    = 0;
  int        stall_left  = 0;
  rx_mode_t  stall_mode  = RX_OPEN;

  logic [POS_W-1:0] sq_pos[QDEPTH];
  int               sq_cnt        = 0;
  logic [POS_W-1:0] seek_ref      = '0;
  bit               seen_dispatch = 1'b0;
  logic [POS_W-1:0] last_pos      = '0;

  sstf_request_scheduler_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Advance the scheduler state by one transfer and return the result it causes.
  function automatic sstf_out_t sstf_next_result(sstf_in_t it);
    sstf_out_t        r;
    logic [POS_W-1:0] anchor;
    logic [POS_W-1:0] pick;
    logic [POS_W-1:0] d;
    logic [POS_W-1:0] best_d;
    int               best;
    r = '0;
    if (it.op == OP_ADD) begin
      if (sq_cnt >= QDEPTH) begin
        r.add_dropped = 1'b1;
      end else begin
        sq_pos[sq_cnt] = it.sector_pos;
        sq_cnt++;
        if (seen_dispatch) begin
          anchor = seek_ref;
          for (int s = 0; s < sq_cnt; s++) begin
            best   = s;
            best_d = (sq_pos[s] > anchor) ? sq_pos[s] - anchor : anchor - sq_pos[s];
            for (int k = s + 1; k < sq_cnt; k++) begin
              d = (sq_pos[k] > anchor) ? sq_pos[k] - anchor : anchor - sq_pos[k];
              if (d < best_d) begin
                best_d = d;
                best   = k;
              end
            end
            pick = sq_pos[best];
            for (int k = best; k > s; k--) sq_pos[k] = sq_pos[k-1];
            sq_pos[s] = pick;
            anchor    = pick;
          end
        end
      end
    end else if (sq_cnt > 0) begin
      r.dispatch_valid = 1'b1;
      r.dispatch_pos   = sq_pos[0];
      for (int k = 0; k < sq_cnt - 1; k++) sq_pos[k] = sq_pos[k+1];
      sq_cnt--;
      seek_ref      = seen_dispatch ? r.dispatch_pos : '0;
      seen_dispatch = 1'b1;
    end
    r.pending_count = sq_cnt[CNT_FIELD_W-1:0];
    return r;
  endfunction

  function automatic void flag_field(string name, longint unsigned want, longint unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    logic [POS_W-1:0] p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p = POS_W'($urandom());
      4:          p = '0;
      5:          p = '1;
      6:          p = last_pos + POS_W'($urandom_range(0, 16)) - POS_W'(8);
      7:          p = last_pos;
      8:          p = POS_W'($urandom_range(0, 63));
      default:    p = '1 - POS_W'($urandom_range(0, 63));
    endcase
    last_pos = p;
    return p;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (stim_q.size() > 0) begin
        in_data  <= stim_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(10, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    sstf_out_t want;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (in_fire) awaited.push_back(sstf_next_result(in_data));
    if (out_fire) begin
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, actual %h", $time, out_data);
      end else begin
        want = awaited.pop_front();
        if (out_data.dispatch_valid !== want.dispatch_valid)
          flag_field("dispatch_valid", want.dispatch_valid, out_data.dispatch_valid);
        if (out_data.dispatch_pos !== want.dispatch_pos)
          flag_field("dispatch_pos", want.dispatch_pos, out_data.dispatch_pos);
        if (out_data.pending_count !== want.pending_count)
          flag_field("pending_count", want.pending_count, out_data.pending_count);
        if (out_data.add_dropped !== want.add_dropped)
          flag_field("add_dropped", want.add_dropped, out_data.add_dropped);
      end
    end
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL sstf_request_scheduler_core");
      $finish;
    end
  end

  task automatic send_item(sstf_op_t op, logic [POS_W-1:0] pos);
    sstf_in_t it;
    it.op         = op;
    it.sector_pos = pos;
    stim_q.push_back(it);
    while (stim_q.size() > 1) @(posedge clk);
  endtask

  task automatic wait_all_done();
    while (stim_q.size() != 0 || in_valid || awaited.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_dispatch();
    send_item(OP_DISPATCH, '1);
  endtask

  task automatic test_append_order();
    send_item(OP_ADD, '0);
    send_item(OP_ADD, '1);
    send_item(OP_ADD, 20'h7FFFF);
    send_item(OP_ADD, 20'h80000);
  endtask

  task automatic test_first_dispatch();
    send_item(OP_DISPATCH, 20'h55555);
    send_item(OP_ADD, 20'h00010);
  endtask

  task automatic test_tie_break();
    send_item(OP_DISPATCH, 20'hAAAAA);
    send_item(OP_ADD, 20'h00020);
    send_item(OP_ADD, 20'h00000);
    send_item(OP_ADD, 20'h00020);
  endtask

  task automatic test_full_drop();
    int n;
    wait_all_done();
    n = QDEPTH - sq_cnt + 1;
    for (int i = 0; i < n; i++) send_item(OP_ADD, (i % 2) ? pick_pos() : ~last_pos);
  endtask

  task automatic test_random(int n_items);
    load_phase_t kind;
    int          span;
    int          add_pct;
    int          sent;
    int          phase_no;
    sent     = 0;
    phase_no = 0;
    while (sent < n_items) begin
      kind    = load_phase_t'($urandom_range(0, 2));
      span    = $urandom_range(8, 60);
      add_pct = (kind == PH_FILL) ? 80 : (kind == PH_DRAIN) ? 20 : 50;
      for (int i = 0; i < span && sent < n_items; i++) begin
        if ($urandom_range(0, 99) < add_pct) send_item(OP_ADD, pick_pos());
        else send_item(OP_DISPATCH, POS_W'($urandom()));
        sent++;
      end
      phase_no++;
      if (phase_no % 6 == 0) wait_all_done();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_dispatch();
    test_append_order();
    test_first_dispatch();
    test_tie_break();
    test_full_drop();
    wait_all_done();
    test_random(N_RANDOM);
    wait_all_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sstf_request_scheduler_core");
    end else begin
      $display("FAIL sstf_request_scheduler_core");
    end
    $finish;
  end

endmodule
